/* rtl/tcst_pkg.sv */
// ---------------------------------------------------------------------------
// tcst_pkg
// Shared types, codes and helpers for the tile command stream tracker.
// ---------------------------------------------------------------------------
`default_nettype none

package tcst_pkg;

	localparam int MASK_W     = 32;
	localparam int GRP_W      = 5;
	localparam int CODE_W     = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POLY_LONG   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_LONG = 1'd1;

	// parameter types
	localparam logic [CODE_W-1:0] PT_END_LIST = 3'd0;
	localparam logic [CODE_W-1:0] PT_TILE_CLIP = 3'd1;
	localparam logic [CODE_W-1:0] PT_LIST_SET = 3'd2;
	localparam logic [CODE_W-1:0] PT_POLY     = 3'd4;
	localparam logic [CODE_W-1:0] PT_SPRITE   = 3'd5;
	localparam logic [CODE_W-1:0] PT_VERTEX   = 3'd7;

	// list types
	localparam logic [CODE_W-1:0] LT_OPAQUE_MOD = 3'd1;
	localparam logic [CODE_W-1:0] LT_TRANS_MOD  = 3'd3;
	localparam logic [CODE_W-1:0] LT_PUNCH      = 3'd4;
	localparam logic [CODE_W-1:0] LT_NONE       = 3'd7;

	typedef enum logic [7:0] {
		ST_NS     = 8'b0000_0001,
		ST_PLV32  = 8'b0000_0010,
		ST_PLV64  = 8'b0000_0100,
		ST_MLV64  = 8'b0000_1000,
		ST_PLHV32 = 8'b0001_0000,
		ST_PLHV64 = 8'b0010_0000,
		ST_PLV64H = 8'b0100_0000,
		ST_MLV64H = 8'b1000_0000
	} parse_state_t;

	typedef struct packed {
		logic              action;
		logic [CODE_W-1:0] para_type;
		logic [CODE_W-1:0] list_type;
		logic [GRP_W-1:0]  obj_group;
	} item_t;

	typedef struct packed {
		logic [CODE_W-1:0] parse_state_out;
		logic              list_end;
		logic [CODE_W-1:0] list_end_kind;
		logic              word_ignored;
		logic              bad_list_type;
		logic [CODE_W-1:0] open_list_out;
	} result_t;

	typedef struct packed {
		logic [MASK_W-1:0] poly_long_mask;
		logic [MASK_W-1:0] vertex_long_mask;
	} masks_t;

	function automatic logic [CODE_W-1:0] state_num(input parse_state_t st);
		logic [CODE_W-1:0] n;
		unique case (st)
			ST_NS:     n = 3'd0;
			ST_PLV32:  n = 3'd1;
			ST_PLV64:  n = 3'd2;
			ST_MLV64:  n = 3'd3;
			ST_PLHV32: n = 3'd4;
			ST_PLHV64: n = 3'd5;
			ST_PLV64H: n = 3'd6;
			ST_MLV64H: n = 3'd7;
			default:   n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

/* rtl/tcst_cfg_regs.sv */
// ---------------------------------------------------------------------------
// tcst_cfg_regs
// Long polygon header and long vertex mask registers.
// ---------------------------------------------------------------------------
`default_nettype none

module tcst_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [tcst_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [tcst_pkg::MASK_W-1:0]      cfg_data,
	output tcst_pkg::masks_t                      masks
);

	logic [tcst_pkg::MASK_W-1:0] poly_long_q;
	logic [tcst_pkg::MASK_W-1:0] vertex_long_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_long_q   <= '0;
			vertex_long_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tcst_pkg::CFG_POLY_LONG:   poly_long_q   <= cfg_data;
				tcst_pkg::CFG_VERTEX_LONG: vertex_long_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign masks.poly_long_mask   = poly_long_q;
	assign masks.vertex_long_mask = vertex_long_q;

endmodule

`default_nettype wire

/* rtl/tcst_parser.sv */
// ---------------------------------------------------------------------------
// tcst_parser
// Parser state, open list register and next-state logic for one word.
// ---------------------------------------------------------------------------
`default_nettype none

module tcst_parser (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire tcst_pkg::item_t  item,
	input  wire tcst_pkg::masks_t masks,
	output tcst_pkg::result_t     result
);

	tcst_pkg::parse_state_t state_q, state_n;
	logic [tcst_pkg::CODE_W-1:0] open_q, open_n;
	logic [tcst_pkg::CODE_W-1:0] eff_list;
	logic                        end_n, ign_n, bad_n;
	logic [tcst_pkg::CODE_W-1:0] kind_n;
	tcst_pkg::parse_state_t      poly_st;
	logic                        p64, v64;

	// list type in force: the open one, or the word's own when none is open
	assign eff_list = (open_q == tcst_pkg::LT_NONE) ? item.list_type : open_q;

	assign p64 = masks.poly_long_mask[item.obj_group];
	assign v64 = masks.vertex_long_mask[item.obj_group];

	always_comb begin
		unique case ({p64, v64})
			2'b11:   poly_st = tcst_pkg::ST_PLHV64;
			2'b10:   poly_st = tcst_pkg::ST_PLHV32;
			2'b01:   poly_st = tcst_pkg::ST_PLV64;
			default: poly_st = tcst_pkg::ST_PLV32;
		endcase
	end

	always_comb begin
		state_n = state_q;
		open_n  = open_q;
		end_n   = 1'b0;
		kind_n  = '0;
		ign_n   = 1'b0;
		bad_n   = 1'b0;
		if (item.action) begin
			state_n = tcst_pkg::ST_NS;
		end else begin
			unique case (state_q)
				// second halves: any word is consumed as the tail
				tcst_pkg::ST_PLHV32: state_n = tcst_pkg::ST_PLV32;
				tcst_pkg::ST_PLHV64,
				tcst_pkg::ST_PLV64H: state_n = tcst_pkg::ST_PLV64;
				tcst_pkg::ST_MLV64H: state_n = tcst_pkg::ST_MLV64;
				default: begin
					unique case (item.para_type)
						tcst_pkg::PT_END_LIST: begin
							if (eff_list <= tcst_pkg::LT_PUNCH) begin
								end_n  = 1'b1;
								kind_n = eff_list;
							end else begin
								bad_n = 1'b1;
							end
							open_n  = tcst_pkg::LT_NONE;
							state_n = tcst_pkg::ST_NS;
						end
						tcst_pkg::PT_TILE_CLIP,
						tcst_pkg::PT_LIST_SET: ;
						tcst_pkg::PT_POLY: begin
							if (state_q == tcst_pkg::ST_NS) begin
								open_n = eff_list;
								if (eff_list == tcst_pkg::LT_OPAQUE_MOD ||
								    eff_list == tcst_pkg::LT_TRANS_MOD)
									state_n = tcst_pkg::ST_MLV64;
								else
									state_n = poly_st;
							end else if (state_q != tcst_pkg::ST_MLV64) begin
								state_n = poly_st;
							end
						end
						tcst_pkg::PT_SPRITE: begin
							if (state_q == tcst_pkg::ST_MLV64) begin
								ign_n = 1'b1;
							end else begin
								if (state_q == tcst_pkg::ST_NS)
									open_n = eff_list;
								state_n = tcst_pkg::ST_PLV64;
							end
						end
						tcst_pkg::PT_VERTEX: begin
							unique case (state_q)
								tcst_pkg::ST_PLV64: state_n = tcst_pkg::ST_PLV64H;
								tcst_pkg::ST_MLV64: state_n = tcst_pkg::ST_MLV64H;
								tcst_pkg::ST_PLV32: ;
								default:            ign_n = 1'b1;
							endcase
						end
						default: ign_n = 1'b1;
					endcase
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcst_pkg::ST_NS;
			open_q  <= tcst_pkg::LT_NONE;
		end else if (step) begin
			state_q <= state_n;
			open_q  <= open_n;
		end
	end

	assign result.parse_state_out = tcst_pkg::state_num(state_n);
	assign result.list_end        = end_n;
	assign result.list_end_kind   = kind_n;
	assign result.word_ignored    = ign_n;
	assign result.bad_list_type   = bad_n;
	assign result.open_list_out   = open_n;

endmodule

`default_nettype wire

/* rtl/tile_command_stream_tracker_core.sv */
// ---------------------------------------------------------------------------
// tile_command_stream_tracker_core
// Command word parser tracking list state and list ends for a tile stream.
// ---------------------------------------------------------------------------
// One word per clock sustained while the result side keeps taking words. A
// word is caught in the input register, goes through the parser's next-state
// logic and lands in the result register, which drives the output. The
// parser state and open list update as the word moves to the
// result register, which keeps back-to-back words dependent on each other
// exact. While a finished word waits on the result side the input register
// can still take one word; after that s_tready stays low until the result is
// taken. Mask writes are taken at any time but should only be made while the
// stream is idle.
`default_nettype none

module tile_command_stream_tracker_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// [2:0] para_type, [5:3] list_type, [10:6] obj_group, [15:11] zero
	input  wire logic [tcst_pkg::IN_DATA_W-1:0]      s_tdata,
	// [0] action
	input  wire logic                                s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// [2:0] parse_state_out, [3] list_end, [6:4] list_end_kind,
	// [7] word_ignored, [8] bad_list_type, [11:9] open_list_out, [15:12] zero
	output logic [tcst_pkg::OUT_DATA_W-1:0]          m_tdata,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [tcst_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [tcst_pkg::MASK_W-1:0]         cfg_data
);

	tcst_pkg::masks_t  masks;
	tcst_pkg::item_t   item_s1;
	tcst_pkg::result_t res_n;
	tcst_pkg::result_t res_s2;
	logic              valid_s1, valid_s2;
	logic              adv_s2, adv_s1;

	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;

	tcst_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.masks     (masks)
	);

	tcst_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.item   (item_s1),
		.masks  (masks),
		.result (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.action    <= s_tuser;
			item_s1.para_type <= s_tdata[2:0];
			item_s1.list_type <= s_tdata[5:3];
			item_s1.obj_group <= s_tdata[10:6];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_n;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0,
	                   res_s2.open_list_out,
	                   res_s2.bad_list_type,
	                   res_s2.word_ignored,
	                   res_s2.list_end_kind,
	                   res_s2.list_end,
	                   res_s2.parse_state_out};

endmodule

`default_nettype wire

/* tb/tcst_track_checker.sv */
// ---------------------------------------------------------------------------
// tcst_track_checker
// Watches the command and result streams of the tile command stream tracker,
// follows the parser and open list for every accepted word, and compares each
// result word field by field with the oldest outstanding prediction.
// ---------------------------------------------------------------------------

module tcst_track_checker
	import tcst_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [MASK_W-1:0]     cfg_data,
	output int                    mismatches,
	output int                    words_in_flight
);
	timeunit 1ns;
	timeprecision 1ps;

	// parser states, numbered as they appear on the result word
	typedef enum logic [CODE_W-1:0] {
		PS_IDLE     = 3'd0,
		PS_POLY_V32 = 3'd1,
		PS_POLY_V64 = 3'd2,
		PS_MOD      = 3'd3,
		PS_HDR_V32  = 3'd4,
		PS_HDR_V64  = 3'd5,
		PS_V64_HALF = 3'd6,
		PS_MOD_HALF = 3'd7
	} trk_state_e;

	logic [MASK_W-1:0] poly_long;
	logic [MASK_W-1:0] vert_long;
	trk_state_e        trk_state;
	logic [CODE_W-1:0] open_lt;
	result_t           list_results_q[$];
	int                fails;
	int                result_no;
	item_t             cmd_w;
	result_t           exp_r;
	result_t           got_r;

	function automatic trk_state_e group_state(input logic [GRP_W-1:0] grp);
		case ({poly_long[grp], vert_long[grp]})
			2'b11:   return PS_HDR_V64;
			2'b10:   return PS_HDR_V32;
			2'b01:   return PS_POLY_V64;
			default: return PS_POLY_V32;
		endcase
	endfunction

	// advances the tracked parser by one word and returns its result word
	function automatic result_t track_word(input item_t w);
		result_t    r;
		trk_state_e nxt;
		r   = '0;
		nxt = trk_state;
		if (w.action) begin
			nxt = PS_IDLE;
		end else if (trk_state == PS_HDR_V32) begin
			nxt = PS_POLY_V32;
		end else if (trk_state == PS_MOD_HALF) begin
			nxt = PS_MOD;
		end else if (trk_state inside {PS_HDR_V64, PS_V64_HALF}) begin
			nxt = PS_POLY_V64;
		end else begin
			case (w.para_type)
				PT_END_LIST: begin
					if (open_lt == LT_NONE)
						open_lt = w.list_type;
					if (open_lt <= LT_PUNCH) begin
						r.list_end      = 1'b1;
						r.list_end_kind = open_lt;
					end else begin
						r.bad_list_type = 1'b1;
					end
					open_lt = LT_NONE;
					nxt     = PS_IDLE;
				end
				PT_TILE_CLIP, PT_LIST_SET: begin
					nxt = trk_state;
				end
				PT_POLY: begin
					if (trk_state == PS_IDLE) begin
						if (open_lt == LT_NONE)
							open_lt = w.list_type;
						if (open_lt == LT_OPAQUE_MOD || open_lt == LT_TRANS_MOD)
							nxt = PS_MOD;
						else
							nxt = group_state(w.obj_group);
					end else if (trk_state == PS_MOD) begin
						nxt = PS_MOD;
					end else begin
						nxt = group_state(w.obj_group);
					end
				end
				PT_SPRITE: begin
					if (trk_state == PS_MOD) begin
						r.word_ignored = 1'b1;
					end else begin
						if (trk_state == PS_IDLE && open_lt == LT_NONE)
							open_lt = w.list_type;
						nxt = PS_POLY_V64;
					end
				end
				PT_VERTEX: begin
					case (trk_state)
						PS_POLY_V32: nxt = PS_POLY_V32;
						PS_POLY_V64: nxt = PS_V64_HALF;
						PS_MOD:      nxt = PS_MOD_HALF;
						default:     r.word_ignored = 1'b1;
					endcase
				end
				default: begin
					r.word_ignored = 1'b1;
				end
			endcase
		end
		trk_state         = nxt;
		r.parse_state_out = nxt;
		r.open_list_out   = open_lt;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_long = '0;
			vert_long = '0;
			trk_state = PS_IDLE;
			open_lt   = LT_NONE;
			list_results_q.delete();
			fails     = 0;
			result_no = 0;
			mismatches      <= 0;
			words_in_flight <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_POLY_LONG:   poly_long = cfg_data;
					CFG_VERTEX_LONG: vert_long = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				cmd_w.action    = s_tuser;
				cmd_w.para_type = s_tdata[2:0];
				cmd_w.list_type = s_tdata[5:3];
				cmd_w.obj_group = s_tdata[10:6];
				list_results_q.insert(list_results_q.size(), track_word(cmd_w));
			end
			if (m_tvalid && m_tready) begin
				got_r.parse_state_out = m_tdata[2:0];
				got_r.list_end        = m_tdata[3];
				got_r.list_end_kind   = m_tdata[6:4];
				got_r.word_ignored    = m_tdata[7];
				got_r.bad_list_type   = m_tdata[8];
				got_r.open_list_out   = m_tdata[11:9];
				if (list_results_q.size() == 0) begin
					if (fails < 10)
						$display("result word %0d arrived with nothing expected: %h",
							result_no, m_tdata);
					fails++;
				end else begin
					exp_r = list_results_q.pop_front();
					if (got_r !== exp_r) begin
						if (fails < 10) begin
							$display("result word %0d mismatch at %0t", result_no, $time);
							$display("  exp state %0d end %b kind %0d ign %b bad %b open %0d",
								exp_r.parse_state_out, exp_r.list_end, exp_r.list_end_kind,
								exp_r.word_ignored, exp_r.bad_list_type, exp_r.open_list_out);
							$display("  got state %0d end %b kind %0d ign %b bad %b open %0d",
								got_r.parse_state_out, got_r.list_end, got_r.list_end_kind,
								got_r.word_ignored, got_r.bad_list_type, got_r.open_list_out);
						end
						fails++;
					end
				end
				result_no++;
			end
			mismatches      <= fails;
			words_in_flight <= list_results_q.size();
		end
	end

endmodule

/* tb/tb_tile_command_stream_tracker_core.sv */
// ---------------------------------------------------------------------------
// tb_tile_command_stream_tracker_core
// Drives command words through the tracker under several mask settings and
// handshake idling patterns; a checker beside the block predicts every result.
// ---------------------------------------------------------------------------

module tb_tile_command_stream_tracker_core;
	timeunit 1ns;
	timeprecision 1ps;

	import tcst_pkg::*;

	localparam logic              ACT_WORD       = 1'b0;
	localparam logic              ACT_SOFT_RESET = 1'b1;
	// para types with no meaning; the parser must ignore them
	localparam logic [CODE_W-1:0] PT_RSV_A       = 3'd3;
	localparam logic [CODE_W-1:0] PT_RSV_B       = 3'd6;
	localparam logic [CODE_W-1:0] LT_OPAQUE      = 3'd0;
	localparam logic [CODE_W-1:0] LT_TRANS       = 3'd2;
	localparam logic [CODE_W-1:0] LT_BAD_5       = 3'd5;
	localparam int                LONG_HOLD      = 300;
	localparam int                PHASES         = 12;
	localparam int                PHASE_WORDS    = 145;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [MASK_W-1:0]     cfg_data;

	int mismatches;
	int words_in_flight;
	int send_idle;
	int recv_stall;
	int hold_req;
	int hold_done;

	tile_command_stream_tracker_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tcst_track_checker u_track_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.words_in_flight (words_in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("FAIL tile_command_stream_tracker_core");
		$finish;
	end

	// result side: random stalls, plus a long hold-off when asked for
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_done) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done++;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	task automatic send_cmd(input logic act, input logic [CODE_W-1:0] pt,
		input logic [CODE_W-1:0] lt, input logic [GRP_W-1:0] grp);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {5'b0, grp, lt, pt};
		do @(posedge clk); while (!s_tready);
	endtask

	// stop offering and let every outstanding result word come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (words_in_flight != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_masks(input logic [MASK_W-1:0] poly, input logic [MASK_W-1:0] vert);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_POLY_LONG;
		cfg_data  <= poly;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_VERTEX_LONG;
		cfg_data  <= vert;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// mostly list traffic, with some soft resets and reserved types mixed in
	function automatic item_t random_cmd();
		item_t w;
		int    p;
		w.action = ($urandom_range(99) < 3) ? ACT_SOFT_RESET : ACT_WORD;
		p = $urandom_range(99);
		if (p < 8)       w.para_type = PT_END_LIST;
		else if (p < 22) w.para_type = PT_POLY;
		else if (p < 28) w.para_type = PT_SPRITE;
		else if (p < 64) w.para_type = PT_VERTEX;
		else if (p < 70) w.para_type = PT_TILE_CLIP;
		else if (p < 76) w.para_type = PT_LIST_SET;
		else if (p < 80) w.para_type = PT_RSV_A;
		else if (p < 84) w.para_type = PT_RSV_B;
		else             w.para_type = CODE_W'($urandom_range(7));
		w.list_type = CODE_W'(($urandom_range(99) < 85) ? $urandom_range(4) :
			$urandom_range(7));
		w.obj_group = GRP_W'($urandom_range(31));
		return w;
	endfunction

	initial begin
		item_t w;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_POLY_LONG;
		cfg_data   = '0;
		send_idle  = 0;
		recv_stall = 0;
		hold_req   = 0;
		hold_done  = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// groups 0 and 31 have long headers, groups 1 and 31 long vertices
		set_masks(32'h8000_0001, 32'h8000_0002);
		send_cmd(ACT_WORD, PT_VERTEX, LT_OPAQUE, 5'd0);
		send_cmd(ACT_WORD, PT_RSV_A, LT_OPAQUE, 5'd0);
		send_cmd(ACT_WORD, PT_RSV_B, LT_OPAQUE, 5'd0);
		send_cmd(ACT_WORD, PT_TILE_CLIP, LT_OPAQUE, 5'd0);
		send_cmd(ACT_WORD, PT_LIST_SET, LT_OPAQUE, 5'd0);
		send_cmd(ACT_WORD, PT_POLY, LT_OPAQUE, 5'd1);
		send_cmd(ACT_WORD, PT_VERTEX, LT_OPAQUE, 5'd0);
		send_cmd(ACT_WORD, PT_RSV_B, LT_OPAQUE, 5'd0);
		send_cmd(ACT_WORD, PT_SPRITE, LT_OPAQUE, 5'd0);
		send_cmd(ACT_WORD, PT_END_LIST, LT_OPAQUE, 5'd0);
		// modifier volume list: sprite is rejected, vertices take two words
		send_cmd(ACT_WORD, PT_POLY, LT_OPAQUE_MOD, 5'd31);
		send_cmd(ACT_WORD, PT_SPRITE, LT_OPAQUE_MOD, 5'd31);
		send_cmd(ACT_WORD, PT_VERTEX, LT_OPAQUE_MOD, 5'd0);
		send_cmd(ACT_WORD, PT_END_LIST, LT_OPAQUE_MOD, 5'd0);
		send_cmd(ACT_WORD, PT_POLY, LT_OPAQUE_MOD, 5'd0);
		send_cmd(ACT_WORD, PT_END_LIST, LT_OPAQUE_MOD, 5'd0);
		// translucent list opened by a sprite, long headers, then soft reset
		send_cmd(ACT_WORD, PT_SPRITE, LT_TRANS, 5'd0);
		send_cmd(ACT_WORD, PT_POLY, LT_TRANS, 5'd0);
		send_cmd(ACT_WORD, PT_RSV_A, LT_TRANS, 5'd0);
		send_cmd(ACT_WORD, PT_VERTEX, LT_TRANS, 5'd0);
		send_cmd(ACT_WORD, PT_POLY, LT_TRANS, 5'd31);
		send_cmd(ACT_SOFT_RESET, PT_VERTEX, LT_NONE, 5'd31);
		send_cmd(ACT_WORD, PT_END_LIST, LT_BAD_5, 5'd0);
		send_cmd(ACT_WORD, PT_POLY, LT_TRANS_MOD, 5'd2);
		send_cmd(ACT_WORD, PT_END_LIST, LT_TRANS_MOD, 5'd2);
		send_cmd(ACT_WORD, PT_POLY, LT_PUNCH, 5'd2);
		send_cmd(ACT_WORD, PT_END_LIST, LT_PUNCH, 5'd2);
		send_cmd(ACT_WORD, PT_END_LIST, LT_NONE, 5'd31);
		drain_results();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 6)
				0: set_masks('0, '0);
				1: set_masks('1, '1);
				2: set_masks('0, '1);
				3: set_masks('1, '0);
				default: set_masks($urandom, $urandom);
			endcase
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 64; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 64; end
				default: begin send_idle = 34; recv_stall = 34; end
			endcase
			// back-pressure long enough to fill the block while words keep coming
			if (ph == 4)
				hold_req++;
			for (int i = 0; i < PHASE_WORDS; i++) begin
				w = random_cmd();
				send_cmd(w.action, w.para_type, w.list_type, w.obj_group);
			end
			drain_results();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && words_in_flight == 0)
			$display("PASS tile_command_stream_tracker_core");
		else
			$display("FAIL tile_command_stream_tracker_core");
		$finish;
	end

endmodule
